// ----- sv/shuffled_lehmer_random_generator_defines.svh -----
// Assertion helpers for the generator's top-level RTL file.
// Each check is clocked by i_clk and is off while i_rst_n is low.
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLRG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/slrg_pkg.sv -----
`timescale 1ns / 1ps

package slrg_pkg;

    // Word width of the generator values and of the seed.
    localparam int WORD_W = 31;

    // Shuffle table geometry; the depth must be a power of two (16 to 64).
    localparam int TABLE_DEPTH = 32;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

    // Core steps run by a reseed: warm-up followed by one step per table slot.
    localparam int WARMUP_STEPS = 8;
    localparam int INIT_STEPS   = TABLE_DEPTH + WARMUP_STEPS;
    localparam int CNT_W        = $clog2(INIT_STEPS);

    // The slot comes from the top address bits of the last output.
    localparam int SLOT_SHIFT = WORD_W - TABLE_AW;

    // Lehmer multiplier and its product width.
    localparam int MUL_W  = 15;
    localparam int PROD_W = WORD_W + MUL_W;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [PROD_W-1:0]   t_prod;
    typedef logic [TABLE_AW-1:0] t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

    localparam logic [MUL_W-1:0] LCG_MUL   = MUL_W'(16807);
    localparam t_word            LCG_MOD   = WORD_W'(32'h7FFF_FFFF);
    localparam t_word            OUT_CLAMP = WORD_W'(32'd2147483389);
    localparam t_word            SEED_ONE  = WORD_W'(1);

endpackage

// ----- sv/slrg_if.sv -----
`timescale 1ns / 1ps

// Request channel: one draw or reseed command per transaction.
interface slrg_in_if import slrg_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  command;
    t_word seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink (input valid, input command, input seed, output ready);
endinterface

// Result channel: one random value per transaction.
interface slrg_out_if import slrg_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

// ----- sv/slrg_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module slrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/slrg_lehmer.sv -----
`timescale 1ns / 1ps

// One Lehmer step: the product is registered, then folded modulo 2^31 - 1
// with a single add and a conditional subtract.
module slrg_lehmer import slrg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_mul_en,
    input  t_word i_x,
    output t_word o_next
);

    t_prod               r_prod;
    t_prod               n_prod;
    logic [WORD_W:0]     fold_sum;
    logic [WORD_W:0]     fold_sub;

    // Multiply stage.
    always_comb begin
        n_prod = r_prod;
        if (i_mul_en) begin
            n_prod = t_prod'(i_x) * t_prod'(LCG_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Mersenne fold: high part wraps onto the low part, then one correction.
    assign fold_sum = {1'b0, r_prod[WORD_W-1:0]}
                    + (WORD_W+1)'(r_prod[PROD_W-1:WORD_W]);
    assign fold_sub = fold_sum - {1'b0, LCG_MOD};
    assign o_next   = (fold_sum >= {1'b0, LCG_MOD}) ? fold_sub[WORD_W-1:0]
                                                    : fold_sum[WORD_W-1:0];

endmodule

// ----- sv/shuffled_lehmer_random_generator.sv -----
// Shuffled Lehmer random generator (minimal standard core with a shuffle table).
// Requests arrive on i_in: command 0 draws the next number, command 1 loads
// the seed field (zero or 2^31 - 1 becomes one) and then draws. Each request
// yields exactly one result transaction on o_out; random_value / (2^31 - 1)
// is the uniform deviate, clamped at 2147483389.
// In a plain draw the accept cycle issues the core multiply and the table
// read, and the next cycle folds the product, writes the slot back and loads
// the output register. A new request is accepted only back in the idle state.
// A reseed runs 40 core steps on the shared multiply and fold unit, each a
// multiply state and then a fold state, followed by the draw itself.
// The first draw after reset seeds itself from one and runs the same steps.
// Reset empties the output register and marks the generator unseeded; the
// table needs no clearing because every seeding fills all of it first.
// A result waits in the output register while the receiver stalls; a new
// request is accepted meanwhile, and its final cycle waits until the output
// register is free.
`timescale 1ns / 1ps
`include "shuffled_lehmer_random_generator_defines.svh"

module shuffled_lehmer_random_generator import slrg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slrg_in_if.sink      i_in,
    slrg_out_if.source   o_out
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_INIT_MUL  = 3'd1;
    localparam logic [2:0] ST_INIT_FOLD = 3'd2;
    localparam logic [2:0] ST_DRAW_MUL  = 3'd3;
    localparam logic [2:0] ST_DRAW_FIN  = 3'd4;

    logic [2:0] r_fsm;
    logic [2:0] n_fsm;
    t_word      r_state;
    t_word      n_state;
    t_word      r_last;
    t_word      n_last;
    t_cnt       r_cnt;
    t_cnt       n_cnt;
    t_addr      r_slot;
    t_addr      n_slot;
    logic       r_out_valid;
    logic       n_out_valid;
    t_word      r_out_val;
    t_word      n_out_val;

    logic       mul_en;
    t_word      lehmer_next;
    logic       mem_we;
    t_addr      mem_waddr;
    logic       mem_re;
    t_word      mem_rdata;
    t_word      seed_raw;
    t_word      seed_fix;
    logic       out_free;

    // Shared core step unit.
    slrg_lehmer u_lehmer (
        .i_clk    (i_clk),
        .i_mul_en (mul_en),
        .i_x      (r_state),
        .o_next   (lehmer_next)
    );

    // Shuffle table.
    slrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (lehmer_next),
        .i_re    (mem_re),
        .i_raddr (n_slot),
        .o_rdata (mem_rdata)
    );

    // Seed selection; a draw before any seeding starts from one.
    assign seed_raw = i_in.command ? i_in.seed : SEED_ONE;
    assign seed_fix = ((seed_raw == '0) || (seed_raw == LCG_MOD)) ? SEED_ONE : seed_raw;

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_fsm == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.random_value = r_out_val;

    // Sequencer and next-state logic.
    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_out_val   = r_out_val;
        n_out_valid = r_out_valid && !o_out.ready;
        mul_en      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_slot;
        mem_re      = 1'b0;

        unique case (r_fsm)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.command || (r_last == '0)) begin
                        n_state = seed_fix;
                        n_cnt   = CNT_W'(INIT_STEPS - 1);
                        n_fsm   = ST_INIT_MUL;
                    end else begin
                        mul_en = 1'b1;
                        mem_re = 1'b1;
                        n_slot = r_last[WORD_W-1:SLOT_SHIFT];
                        n_fsm  = ST_DRAW_FIN;
                    end
                end
            end
            ST_INIT_MUL: begin
                mul_en = 1'b1;
                n_fsm  = ST_INIT_FOLD;
            end
            ST_INIT_FOLD: begin
                n_state = lehmer_next;
                // The table fills from the highest slot down to slot 0.
                if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt[TABLE_AW-1:0];
                end
                if (r_cnt == '0) begin
                    n_last = lehmer_next;
                    n_fsm  = ST_DRAW_MUL;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                    n_fsm = ST_INIT_MUL;
                end
            end
            ST_DRAW_MUL: begin
                mul_en = 1'b1;
                mem_re = 1'b1;
                n_slot = r_last[WORD_W-1:SLOT_SHIFT];
                n_fsm  = ST_DRAW_FIN;
            end
            ST_DRAW_FIN: begin
                // Return the old slot value and refill the slot.
                if (out_free) begin
                    n_state     = lehmer_next;
                    mem_we      = 1'b1;
                    n_last      = mem_rdata;
                    n_out_val   = (mem_rdata > OUT_CLAMP) ? OUT_CLAMP : mem_rdata;
                    n_out_valid = 1'b1;
                    n_fsm       = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_state     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_slot    <= n_slot;
        r_out_val <= n_out_val;
    end

    // A result in the output register always lies in the documented range.
    `SLRG_ASSERT_NOW(a_out_range, r_out_valid, (r_out_val != '0) && (r_out_val <= OUT_CLAMP), "result out of range")

    // A draw on a seeded generator goes straight to its final cycle.
    `SLRG_ASSERT_NEXT(a_fast_draw, i_in.valid && i_in.ready && !i_in.command && (r_last != '0), r_fsm == ST_DRAW_FIN, "seeded draw did not take the short path")

    // The last core step of a seeding marks the generator seeded.
    `SLRG_ASSERT_NEXT(a_init_done, (r_fsm == ST_INIT_FOLD) && (r_cnt == '0), (r_fsm == ST_DRAW_MUL) && (r_last != '0), "seeding did not finish cleanly")

    // The core never holds zero while a draw completes.
    `SLRG_ASSERT_NOW(a_core_live, r_fsm == ST_DRAW_FIN, r_state != '0, "core state is zero during a draw")

    // The folded core step stays below the modulus.
    `SLRG_ASSERT_NOW(a_fold_range, r_fsm == ST_INIT_FOLD, lehmer_next != LCG_MOD, "core step not reduced")

endmodule

// ----- dv/slrg_test_pkg.sv -----
`timescale 1ns / 1ps

package slrg_test_pkg;
    import slrg_pkg::*;

    // Request command codes.
    typedef enum logic {
        CMD_DRAW   = 1'b0,
        CMD_RESEED = 1'b1
    } t_command;

    // Inverse of the Lehmer multiplier modulo 2^31 - 1, used to walk the core backwards.
    localparam longint unsigned LCG_MUL_INV = 64'd1407677000;

    // Width of the value range that maps onto one shuffle slot.
    localparam t_word SLOT_DIV = t_word'(1 + (int'(LCG_MOD) - 1) / TABLE_DEPTH);

    // One core step: multiply by the Lehmer constant modulo 2^31 - 1.
    function automatic t_word lehmer_step(input t_word x);
        return t_word'((64'(x) * 64'(LCG_MUL)) % 64'(LCG_MOD));
    endfunction

    // One core step backwards.
    function automatic t_word lehmer_unstep(input t_word x);
        return t_word'((64'(x) * LCG_MUL_INV) % 64'(LCG_MOD));
    endfunction

endpackage

// ----- dv/slrg_checker.sv -----
`timescale 1ns / 1ps

module slrg_checker import slrg_pkg::*; import slrg_test_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    slrg_in_if   i_req,
    slrg_out_if  i_res,
    output int   o_mismatch_count,
    output int   o_expected_count
);

    // Predicted generator state.
    t_word core_state;
    t_word shuffle_slots [TABLE_DEPTH];
    t_word prev_value;
    t_word expected_values [$];
    int    mismatch_count = 0;

    // Load a seed, run the warm-up steps and fill the table from the top slot down.
    task automatic load_seed(input t_word seed);
        t_word x;
        int    n;
        x = seed;
        if (x == '0 || x == LCG_MOD) begin
            x = SEED_ONE;
        end
        for (n = INIT_STEPS - 1; n >= 0; n--) begin
            x = lehmer_step(x);
            if (n < TABLE_DEPTH) begin
                shuffle_slots[n] = x;
            end
        end
        core_state = x;
        prev_value = shuffle_slots[0];
    endtask

    // Work out the value that one request returns and update the predicted state.
    task automatic draw_value(input logic command, input t_word seed, output t_word value);
        t_word slot;
        if (command == CMD_RESEED) begin
            load_seed(seed);
        end else if (prev_value == '0) begin
            load_seed(SEED_ONE);
        end
        core_state = lehmer_step(core_state);
        slot = prev_value / SLOT_DIV;
        if (slot >= TABLE_DEPTH) begin
            slot = t_word'(TABLE_DEPTH - 1);
        end
        prev_value = shuffle_slots[slot];
        shuffle_slots[slot] = core_state;
        value = (prev_value > OUT_CLAMP) ? OUT_CLAMP : prev_value;
    endtask

    // Predict on each request transaction and compare each result transaction.
    always @(posedge i_clk) begin
        t_word predicted;
        t_word oldest;
        if (!i_rst_n) begin
            core_state = '0;
            prev_value = '0;
            expected_values.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                draw_value(i_req.command, i_req.seed, predicted);
                expected_values.push_back(predicted);
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_values.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual random_value %0d",
                             $time, i_res.random_value);
                end else begin
                    oldest = expected_values.pop_front();
                    if (i_res.random_value !== oldest) begin
                        mismatch_count++;
                        $display("%0t: random_value mismatch, expected %0d, actual %0d",
                                 $time, oldest, i_res.random_value);
                    end
                end
            end
        end
        o_expected_count <= expected_values.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

// ----- dv/shuffled_lehmer_random_generator_test.sv -----
`timescale 1ns / 1ps

module shuffled_lehmer_random_generator_test;
    import slrg_pkg::*;
    import slrg_test_pkg::*;

    localparam int RANDOM_ITEMS = 1925;
    localparam int MAX_GAP      = 17;
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slrg_in_if  in_if ();
    slrg_out_if out_if ();

    int mismatch_count;
    int expected_count;
    int draws_sent    = 0;
    int reseeds_sent  = 0;
    int results_taken = 0;
    int idle_cycles   = 0;
    bit sender_burst  = 1'b0;
    bit receiver_burst = 1'b0;

    shuffled_lehmer_random_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    slrg_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (in_if),
        .i_res            (out_if),
        .o_mismatch_count (mismatch_count),
        .o_expected_count (expected_count)
    );

    always #1 i_clk = ~i_clk;

    // Issue one request transaction, after a random gap unless in burst mode.
    task automatic send_request(input t_command command, input t_word seed);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.command <= command;
        in_if.seed    <= seed;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (command == CMD_RESEED) begin
            reseeds_sent++;
        end else begin
            draws_sent++;
        end
    endtask

    // Wait until every outstanding result has been taken.
    task automatic wait_drained();
        @(posedge i_clk);
        while (expected_count != 0) @(posedge i_clk);
    endtask

    // Result side: stall at random before each transaction, except in burst mode.
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                receiver_burst = !receiver_burst;
            end
            gap = receiver_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            results_taken++;
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict.
    initial begin
        t_word    clamp_seed;
        t_word    s;
        t_word    x;
        t_command command;
        t_word    seed;
        int       v;
        int       k;
        int       i;
        bit       found;

        in_if.valid   <= 1'b0;
        in_if.command <= CMD_DRAW;
        in_if.seed    <= '0;
        i_rst_n       <= 1'b0;

        // Find a seed whose first draw returns a table value above the clamp:
        // place a large value in slot k and keep it only if slot 0 selects slot k.
        clamp_seed = SEED_ONE;
        found = 1'b0;
        for (v = int'(LCG_MOD) - 1; v > int'(OUT_CLAMP) && !found; v--) begin
            for (k = 1; k < TABLE_DEPTH && !found; k++) begin
                s = t_word'(v);
                repeat (INIT_STEPS - k) s = lehmer_unstep(s);
                x = s;
                repeat (INIT_STEPS) x = lehmer_step(x);
                if (x / SLOT_DIV == t_word'(k)) begin
                    clamp_seed = s;
                    found = 1'b1;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: unseeded draw, seed extremes, clamp case, alternating seed bits.
        send_request(CMD_DRAW, LCG_MOD);
        send_request(CMD_DRAW, '0);
        send_request(CMD_DRAW, t_word'(12345));
        send_request(CMD_RESEED, '0);
        send_request(CMD_DRAW, '0);
        send_request(CMD_RESEED, LCG_MOD);
        send_request(CMD_DRAW, LCG_MOD);
        send_request(CMD_RESEED, SEED_ONE);
        send_request(CMD_RESEED, LCG_MOD - SEED_ONE);
        send_request(CMD_DRAW, '0);
        send_request(CMD_RESEED, clamp_seed);
        send_request(CMD_DRAW, '0);
        send_request(CMD_DRAW, '0);
        send_request(CMD_RESEED, t_word'(31'h5555_5555));
        send_request(CMD_DRAW, t_word'(31'h2AAA_AAAA));
        send_request(CMD_RESEED, t_word'(31'h2AAA_AAAA));
        sender_burst = 1'b1;
        repeat (8) send_request(CMD_DRAW, t_word'($urandom));
        sender_burst = 1'b0;

        // Random part: mostly draws with occasional reseeds of varied seeds.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                sender_burst = !sender_burst;
            end
            command = ($urandom_range(0, 7) == 0) ? CMD_RESEED : CMD_DRAW;
            case ($urandom_range(0, 7))
                0: seed = t_word'($urandom_range(0, 3));
                1: seed = LCG_MOD - t_word'($urandom_range(0, 7));
                default: seed = t_word'($urandom);
            endcase
            send_request(command, seed);
            if (i == RANDOM_ITEMS / 2) begin
                in_if.valid <= 1'b0;
                wait_drained();
            end
        end
        in_if.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d draws and %0d reseeds, took %0d results (clamp-case seed %0d).",
                 draws_sent, reseeds_sent, results_taken, clamp_seed);
        $display("Covered unseeded draws, zero and modulus seeds, bursts and random stalls.");
        if (mismatch_count == 0 && expected_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
